@@ sv/gapp_pkg.sv @@
// Shared types and constants for the grid A* path planner.
// No dependencies.
package gapp_pkg;

    localparam int MAX_RESULTS   = 42;
    localparam int COST_STRAIGHT = 10;
    localparam int COST_DIAG     = 14;

    // cell table entry mode; unseen must be zero so a cleared word reads unseen
    typedef enum logic [1:0] {
        MODE_UNSEEN = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_CLOSED = 2'd2
    } t_mode;

    // result status codes
    typedef enum logic [1:0] {
        STAT_PATH    = 2'd0,
        STAT_BLOCKED = 2'd1,
        STAT_RANGE   = 2'd2
    } t_status;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_INIT,
        S_CHECK,
        S_NB_ADDR,
        S_NB_EVAL,
        S_SCAN,
        S_CLOSE,
        S_TR_RD,
        S_TR_WR,
        S_EM_RD,
        S_EM_LOAD,
        S_OUT
    } t_state;

endpackage

@@ sv/gapp_if.sv @@
// Request and response channel interfaces of the grid A* path planner.
// Depends on nothing but the field widths of the planner.
interface gapp_req_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] start_x;
    logic signed [7:0] start_y;
    logic signed [7:0] goal_x;
    logic signed [7:0] goal_y;
    logic signed [7:0] obstacle_x;
    logic signed [7:0] obstacle_y;

    modport source (output valid, start_x, start_y, goal_x, goal_y, obstacle_x, obstacle_y,
                    input ready);
    modport sink (input valid, start_x, start_y, goal_x, goal_y, obstacle_x, obstacle_y,
                  output ready);
    modport monitor (input valid, ready, start_x, start_y, goal_x, goal_y,
                     obstacle_x, obstacle_y);
endinterface

interface gapp_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [4:0] cell_x;
    logic signed [4:0] cell_y;
    logic              last;
    logic [1:0]        status;

    modport source (output valid, cell_x, cell_y, last, status, input ready);
    modport sink (input valid, cell_x, cell_y, last, status, output ready);
    modport monitor (input valid, ready, cell_x, cell_y, last, status);
endinterface

@@ sv/gapp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gapp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/grid_astar_path_planner_unit.sv @@
// Grid A* path planner top level: sequencer, cell table and path stack.
// Depends on gapp_pkg, gapp_if.sv and gapp_ram.
//
//   channel  | dir | word                                         | handshake
//   i_req    | in  | start_x/y, goal_x/y, obstacle_x/y (8b signed) | valid/ready
//   o_rsp    | out | cell_x/y (5b signed), last, status            | valid/ready
//
// One request at a time; i_req.ready is high only when the planner is idle.
// Per request: table clear (S*S words, S = 2*GRID_HALF+1), then per expansion a
// neighbor read/update and an open-list scan on the single cell table read port,
// then the path trace and the word emission, which output stalls can hold.
// Off-grid and goal-on-obstacle requests answer straight from idle, with no search.
// Reset (synchronous, active low) returns the sequencer to idle, response empty.
module grid_astar_path_planner_unit
    import gapp_pkg::*;
#(
    parameter int GRID_HALF = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gapp_req_if.sink    i_req,
    gapp_rsp_if.source  o_rsp
);
    localparam int SIDE  = 2 * GRID_HALF + 1;
    localparam int CELLS = SIDE * SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_HALF + 2) + 1;
    localparam int GW    = $clog2(CELLS * COST_DIAG + 40 * GRID_HALF + 1);
    localparam int OW    = $clog2(CELLS + 1);
    localparam int CNT_W = $clog2(((CELLS > MAX_RESULTS) ? CELLS : MAX_RESULTS) + 1);

    typedef struct packed {
        t_mode                 mode;
        logic                  has_par;
        logic signed [XW-1:0]  par_x;
        logic signed [XW-1:0]  par_y;
        logic [GW-1:0]         g;
        logic [GW-1:0]         f;
        logic [OW-1:0]         order;
    } t_cell;

    localparam int EW = $bits(t_cell);
    localparam int PW = 2 * XW;

    localparam logic signed [7:0]    HALF8  = 8'(GRID_HALF);
    localparam logic signed [XW-1:0] HALFX  = XW'(GRID_HALF);

    // grid membership of an 8-bit coordinate pair
    function automatic logic on_grid8(logic signed [7:0] x, logic signed [7:0] y);
        return (x >= -HALF8) && (x <= HALF8) && (y >= -HALF8) && (y <= HALF8);
    endfunction

    // cell table address of an on-grid coordinate pair
    function automatic logic [AW-1:0] idx_of(logic signed [XW-1:0] x,
                                             logic signed [XW-1:0] y);
        logic [XW-1:0] ux;
        logic [XW-1:0] uy;
        ux = XW'(x + HALFX);
        uy = XW'(y + HALFX);
        return AW'(AW'(ux) * AW'(SIDE)) + AW'(uy);
    endfunction

    // ---- registers ----
    t_state               r_state, n_state;
    logic signed [7:0]    r_gx, n_gx, r_gy, n_gy, r_ox, n_ox, r_oy, n_oy;
    logic signed [7:0]    r_sx, n_sx, r_sy, n_sy;
    logic [CNT_W-1:0]     r_addr, n_addr;
    logic signed [XW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [GW-1:0]        r_cur_g, n_cur_g;
    logic [OW-1:0]        r_ins, n_ins;
    logic [2:0]           r_nb, n_nb;
    logic signed [XW-1:0] r_scx, n_scx, r_scy, n_scy;
    logic                 r_pv, n_pv;
    logic signed [XW-1:0] r_px, n_px, r_py, n_py;
    logic                 r_best_v, n_best_v;
    t_cell                r_best, n_best;
    logic signed [XW-1:0] r_bx, n_bx, r_by, n_by;
    logic [CNT_W-1:0]     r_len, n_len, r_cnt, n_cnt, r_k, n_k;
    logic signed [4:0]    r_ox5, n_ox5, r_oy5, n_oy5;
    logic                 r_olast, n_olast;
    t_status              r_ostat, n_ostat;
    logic                 r_ovalid, n_ovalid;

    // ---- memories ----
    logic            cm_we;
    logic [AW-1:0]   cm_waddr, cm_raddr;
    t_cell           cm_wdata, cm_rdata;
    logic            pm_we;
    logic [AW-1:0]   pm_waddr, pm_raddr;
    logic [PW-1:0]   pm_wdata, pm_rdata;

    gapp_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wdata (cm_wdata),
        .i_raddr (cm_raddr),
        .o_rdata (cm_rdata)
    );

    gapp_ram #(.WIDTH(PW), .DEPTH(CELLS)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (pm_we),
        .i_waddr (pm_waddr),
        .i_wdata (pm_wdata),
        .i_raddr (pm_raddr),
        .o_rdata (pm_rdata)
    );

    // ---- neighbor geometry: dx outer, dy inner, center skipped ----
    logic signed [1:0]    nb_dx, nb_dy;
    logic signed [XW-1:0] nx, ny;
    logic                 nb_ok;
    logic signed [XW:0]   hdx, hdy;
    logic [XW+1:0]        hsum;
    logic [GW-1:0]        nb_g, nb_f;

    always_comb begin
        unique case (r_nb)
            3'd0: begin nb_dx = -2'sd1; nb_dy = -2'sd1; end
            3'd1: begin nb_dx = -2'sd1; nb_dy =  2'sd0; end
            3'd2: begin nb_dx = -2'sd1; nb_dy =  2'sd1; end
            3'd3: begin nb_dx =  2'sd0; nb_dy = -2'sd1; end
            3'd4: begin nb_dx =  2'sd0; nb_dy =  2'sd1; end
            3'd5: begin nb_dx =  2'sd1; nb_dy = -2'sd1; end
            3'd6: begin nb_dx =  2'sd1; nb_dy =  2'sd0; end
            default: begin nb_dx = 2'sd1; nb_dy = 2'sd1; end
        endcase
        nx    = r_cx + XW'(nb_dx);
        ny    = r_cy + XW'(nb_dy);
        nb_ok = (nx >= -HALFX) && (nx <= HALFX) && (ny >= -HALFX) && (ny <= HALFX)
                && !((8'(nx) == r_ox) && (8'(ny) == r_oy));
        // Manhattan heuristic, times 10 as shift-add
        hdx   = (XW + 1)'(r_gx) - (XW + 1)'(nx);
        hdy   = (XW + 1)'(r_gy) - (XW + 1)'(ny);
        hsum  = (XW + 2)'(hdx < 0 ? -hdx : hdx) + (XW + 2)'(hdy < 0 ? -hdy : hdy);
        nb_g  = r_cur_g + GW'((nb_dx == 0 || nb_dy == 0) ? COST_STRAIGHT : COST_DIAG);
        nb_f  = nb_g + (GW'(hsum) << 3) + (GW'(hsum) << 1);
    end

    // ---- sequencer ----
    always_comb begin
        n_state  = r_state;
        n_sx = r_sx; n_sy = r_sy; n_gx = r_gx; n_gy = r_gy; n_ox = r_ox; n_oy = r_oy;
        n_addr   = r_addr;
        n_cx = r_cx; n_cy = r_cy;
        n_cur_g  = r_cur_g;
        n_ins    = r_ins;
        n_nb     = r_nb;
        n_scx = r_scx; n_scy = r_scy;
        n_pv     = r_pv;
        n_px = r_px; n_py = r_py;
        n_best_v = r_best_v;
        n_best   = r_best;
        n_bx = r_bx; n_by = r_by;
        n_len = r_len; n_cnt = r_cnt; n_k = r_k;
        n_ox5 = r_ox5; n_oy5 = r_oy5;
        n_olast  = r_olast;
        n_ostat  = r_ostat;
        n_ovalid = r_ovalid;
        cm_we    = 1'b0;
        cm_waddr = '0;
        cm_wdata = '0;
        cm_raddr = '0;
        pm_we    = 1'b0;
        pm_waddr = r_len[AW-1:0];
        pm_wdata = {r_cx, r_cy};
        pm_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_sx = i_req.start_x; n_sy = i_req.start_y;
                    n_gx = i_req.goal_x;  n_gy = i_req.goal_y;
                    n_ox = i_req.obstacle_x; n_oy = i_req.obstacle_y;
                    n_ox5 = '0; n_oy5 = '0; n_olast = 1'b1;
                    n_addr = '0;
                    if (on_grid8(i_req.goal_x, i_req.goal_y)
                        && i_req.goal_x == i_req.obstacle_x
                        && i_req.goal_y == i_req.obstacle_y) begin
                        n_ostat = STAT_BLOCKED; n_ovalid = 1'b1; n_state = S_OUT;
                    end else if (!on_grid8(i_req.start_x, i_req.start_y)
                                 || !on_grid8(i_req.goal_x, i_req.goal_y)) begin
                        n_ostat = STAT_RANGE; n_ovalid = 1'b1; n_state = S_OUT;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            // wipe the table, one word a cycle
            S_CLEAR: begin
                cm_we    = 1'b1;
                cm_waddr = r_addr[AW-1:0];
                n_addr   = r_addr + 1'b1;
                if (r_addr == CNT_W'(CELLS - 1)) begin
                    n_state = S_INIT;
                end
            end
            // start cell closed, order 0, no parent
            S_INIT: begin
                n_cx = XW'(r_sx); n_cy = XW'(r_sy);
                cm_we          = 1'b1;
                cm_waddr       = idx_of(XW'(r_sx), XW'(r_sy));
                cm_wdata.mode  = MODE_CLOSED;
                n_ins   = OW'(1);
                n_cur_g = '0;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (8'(r_cx) == r_gx && 8'(r_cy) == r_gy) begin
                    n_len = '0; n_state = S_TR_RD;
                end else begin
                    n_nb = '0; n_state = S_NB_ADDR;
                end
            end
            S_NB_ADDR: begin
                cm_raddr = idx_of(nx, ny);
                if (nb_ok) begin
                    n_state = S_NB_EVAL;
                end else if (r_nb == 3'd7) begin
                    n_addr = '0; n_scx = -HALFX; n_scy = -HALFX;
                    n_pv = 1'b0; n_best_v = 1'b0; n_state = S_SCAN;
                end else begin
                    n_nb = r_nb + 1'b1;
                end
            end
            // open or relax the neighbor
            S_NB_EVAL: begin
                cm_waddr       = idx_of(nx, ny);
                cm_wdata.mode  = MODE_OPEN;
                cm_wdata.has_par = 1'b1;
                cm_wdata.par_x = r_cx;
                cm_wdata.par_y = r_cy;
                cm_wdata.g     = nb_g;
                cm_wdata.f     = nb_f;
                cm_wdata.order = cm_rdata.order;
                if (cm_rdata.mode == MODE_UNSEEN) begin
                    cm_we = 1'b1;
                    cm_wdata.order = r_ins;
                    n_ins = r_ins + 1'b1;
                end else if (cm_rdata.mode == MODE_OPEN && nb_f <= cm_rdata.f) begin
                    cm_we = 1'b1;
                end
                if (r_nb == 3'd7) begin
                    n_addr = '0; n_scx = -HALFX; n_scy = -HALFX;
                    n_pv = 1'b0; n_best_v = 1'b0; n_state = S_SCAN;
                end else begin
                    n_nb = r_nb + 1'b1; n_state = S_NB_ADDR;
                end
            end
            // open-list minimum: issue one address a cycle, compare the word behind it
            S_SCAN: begin
                cm_raddr = r_addr[AW-1:0];
                if (r_addr != CNT_W'(CELLS)) begin
                    n_pv = 1'b1; n_px = r_scx; n_py = r_scy;
                    n_addr = r_addr + 1'b1;
                    if (r_scy == HALFX) begin
                        n_scy = -HALFX; n_scx = r_scx + 1'b1;
                    end else begin
                        n_scy = r_scy + 1'b1;
                    end
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = S_CLOSE;
                    end
                end
                if (r_pv && cm_rdata.mode == MODE_OPEN
                    && (!r_best_v || cm_rdata.f < r_best.f
                        || (cm_rdata.f == r_best.f && cm_rdata.order < r_best.order))) begin
                    n_best_v = 1'b1; n_best = cm_rdata; n_bx = r_px; n_by = r_py;
                end
            end
            S_CLOSE: begin
                if (!r_best_v) begin
                    n_ox5 = '0; n_oy5 = '0; n_olast = 1'b1;
                    n_ostat = STAT_BLOCKED; n_ovalid = 1'b1; n_state = S_OUT;
                end else begin
                    cm_we         = 1'b1;
                    cm_waddr      = idx_of(r_bx, r_by);
                    cm_wdata      = r_best;
                    cm_wdata.mode = MODE_CLOSED;
                    n_cx = r_bx; n_cy = r_by;
                    n_cur_g = r_best.g;
                    n_state = S_CHECK;
                end
            end
            // walk parent links from the goal, pushing each cell
            S_TR_RD: begin
                cm_raddr = idx_of(r_cx, r_cy);
                n_state  = S_TR_WR;
            end
            S_TR_WR: begin
                pm_we = 1'b1;
                n_len = r_len + 1'b1;
                if (!cm_rdata.has_par || r_len == CNT_W'(CELLS - 1)) begin
                    n_cnt = ((r_len + 1'b1) < CNT_W'(MAX_RESULTS)) ? (r_len + 1'b1)
                                                                   : CNT_W'(MAX_RESULTS);
                    n_k = '0;
                    n_state = S_EM_RD;
                end else begin
                    n_cx = cm_rdata.par_x; n_cy = cm_rdata.par_y;
                    n_state = S_TR_RD;
                end
            end
            // pop from the start end
            S_EM_RD: begin
                pm_raddr = AW'(r_len - r_k - 1'b1);
                n_state  = S_EM_LOAD;
            end
            S_EM_LOAD: begin
                n_oy5 = 5'($signed(pm_rdata[XW-1:0]));
                n_ox5 = 5'($signed(pm_rdata[PW-1:XW]));
                n_olast  = (r_k == r_cnt - 1'b1);
                n_ostat  = STAT_PATH;
                n_ovalid = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_state = S_EM_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_sx <= n_sx; r_sy <= n_sy; r_gx <= n_gx; r_gy <= n_gy; r_ox <= n_ox; r_oy <= n_oy;
        r_addr <= n_addr;
        r_cx <= n_cx; r_cy <= n_cy;
        r_cur_g <= n_cur_g;
        r_ins <= n_ins;
        r_nb <= n_nb;
        r_scx <= n_scx; r_scy <= n_scy;
        r_pv <= n_pv;
        r_px <= n_px; r_py <= n_py;
        r_best_v <= n_best_v;
        r_best <= n_best;
        r_bx <= n_bx; r_by <= n_by;
        r_len <= n_len; r_cnt <= n_cnt; r_k <= n_k;
        r_ox5 <= n_ox5; r_oy5 <= n_oy5;
        r_olast <= n_olast;
        r_ostat <= n_ostat;
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_ovalid;
    assign o_rsp.cell_x = r_ox5;
    assign o_rsp.cell_y = r_oy5;
    assign o_rsp.last   = r_olast;
    assign o_rsp.status = r_ostat;
endmodule

@@ sv/gapp_checker.sv @@
// Port-level checks for the grid A* path planner, bound to the top level.
// Depends on gapp_pkg, gapp_if.sv and grid_astar_path_planner_unit.
module gapp_checker
    import gapp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic signed [4:0] i_rsp_cell_x,
    input logic signed [4:0] i_rsp_cell_y,
    input logic              i_rsp_last,
    input logic [1:0]        i_rsp_status
);
    // one request in flight: no new word taken while a response word is shown
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !i_req_ready)
        else $error("request ready while response valid");

    // after a request is taken the planner stays busy the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("ready right after accepting a request");

    // error statuses are single-word replies
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status == STAT_BLOCKED || i_rsp_status == STAT_RANGE))
        |-> (i_rsp_last && i_rsp_cell_x == 5'sd0 && i_rsp_cell_y == 5'sd0))
        else $error("error status without last or with nonzero cell");

    // stalled response word holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_cell_x)
            && $stable(i_rsp_cell_y) && $stable(i_rsp_last) && $stable(i_rsp_status)))
        else $error("response word changed under stall");
endmodule

bind grid_astar_path_planner_unit gapp_checker u_gapp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_cell_x (o_rsp.cell_x),
    .i_rsp_cell_y (o_rsp.cell_y),
    .i_rsp_last   (o_rsp.last),
    .i_rsp_status (o_rsp.status)
);

@@ tb/tb_grid_astar_path_planner_unit.sv @@
// Self-checking testbench for grid_astar_path_planner_unit: directed requests from a table,
// then random requests, checked against an in-bench A* path predictor or a typed-in status.
// Depends on gapp_pkg, gapp_if.sv and the planner RTL.
module tb_grid_astar_path_planner_unit;
    import gapp_pkg::*;

    localparam int GH        = 10;
    localparam int SIDE      = 2 * GH + 1;
    localparam int NCELL     = SIDE * SIDE;
    localparam int N_RANDOM  = 80;
    localparam int HOLD_LONG = 3000;
    localparam int LIMIT     = 120_000_000;

    typedef struct {
        logic signed [4:0] x;
        logic signed [4:0] y;
        logic              last;
        t_status           st;
    } t_cell_word;

    // directed row: six coordinates, plus a typed-in status where it is obvious
    typedef struct {
        int      sx, sy, gx, gy, ox, oy;
        bit      typed;
        t_status st;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    gapp_req_if req_if();
    gapp_rsp_if rsp_if();

    grid_astar_path_planner_unit #(.GRID_HALF(GH)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_cell_word path_q[$];
    int  errors = 0;
    int  n_req = 0, n_words = 0, n_blocked = 0, n_range = 0;
    int  cycles = 0;
    bit  cur_typed = 0;
    t_status cur_st = STAT_PATH;
    bit  random_phase = 0;
    bit  hold_done = 0;

    // predictor search table
    t_mode      pm_mode[NCELL];
    int         pm_g[NCELL], pm_f[NCELL], pm_ord[NCELL], pm_par[NCELL];
    bit         pm_hp[NCELL];
    int         trace[NCELL];

    function automatic bit in_grid(int x, int y);
        return x >= -GH && x <= GH && y >= -GH && y <= GH;
    endfunction

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void push_word(int x, int y, bit last, t_status st);
        t_cell_word w;
        w.x = x[4:0];
        w.y = y[4:0];
        w.last = last;
        w.st = st;
        path_q.push_back(w);
    endfunction

    // expected path words of one request
    function automatic void plan_path(int sx, int sy, int gx, int gy, int ox, int oy);
        int cur, cx, cy, best, nx, ny, n, g, f, cnt, len, node, ins;
        if (in_grid(gx, gy) && gx == ox && gy == oy) begin
            push_word(0, 0, 1, STAT_BLOCKED);
            return;
        end
        if (!in_grid(sx, sy) || !in_grid(gx, gy)) begin
            push_word(0, 0, 1, STAT_RANGE);
            return;
        end
        for (int i = 0; i < NCELL; i++) begin
            pm_mode[i] = MODE_UNSEEN;
            pm_g[i] = 0; pm_f[i] = 0; pm_ord[i] = 0; pm_par[i] = 0; pm_hp[i] = 0;
        end
        ins = 0;
        cur = (sx + GH) * SIDE + (sy + GH);
        pm_mode[cur] = MODE_CLOSED;
        pm_ord[cur] = ins++;
        cx = sx;
        cy = sy;
        while (!(cx == gx && cy == gy)) begin
            // visit neighbors, dx outer, dy inner
            for (int dx = -1; dx <= 1; dx++) begin
                for (int dy = -1; dy <= 1; dy++) begin
                    nx = cx + dx;
                    ny = cy + dy;
                    if (dx == 0 && dy == 0) continue;
                    if (!in_grid(nx, ny)) continue;
                    if (nx == ox && ny == oy) continue;
                    n = (nx + GH) * SIDE + (ny + GH);
                    if (pm_mode[n] == MODE_CLOSED) continue;
                    g = pm_g[cur] + ((dx == 0 || dy == 0) ? COST_STRAIGHT : COST_DIAG);
                    f = g + (iabs(gx - nx) + iabs(gy - ny)) * 10;
                    if (pm_mode[n] == MODE_UNSEEN) begin
                        pm_mode[n] = MODE_OPEN;
                        pm_ord[n] = ins++;
                    end else if (f > pm_f[n]) begin
                        continue;
                    end
                    pm_g[n] = g;
                    pm_f[n] = f;
                    pm_par[n] = cur;
                    pm_hp[n] = 1;
                end
            end
            // lowest f, then earliest insertion
            best = -1;
            for (int i = 0; i < NCELL; i++) begin
                if (pm_mode[i] != MODE_OPEN) continue;
                if (best < 0 || pm_f[i] < pm_f[best] ||
                    (pm_f[i] == pm_f[best] && pm_ord[i] < pm_ord[best]))
                    best = i;
            end
            if (best < 0) begin
                push_word(0, 0, 1, STAT_BLOCKED);
                return;
            end
            pm_mode[best] = MODE_CLOSED;
            cur = best;
            cx = best / SIDE - GH;
            cy = best % SIDE - GH;
        end
        len = 0;
        node = cur;
        while (len < NCELL) begin
            trace[len++] = node;
            if (!pm_hp[node]) break;
            node = pm_par[node];
        end
        cnt = len < MAX_RESULTS ? len : MAX_RESULTS;
        for (int k = 0; k < cnt; k++) begin
            node = trace[len - 1 - k];
            push_word(node / SIDE - GH, node % SIDE - GH, k == cnt - 1, STAT_PATH);
        end
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // accepted request: queue its expected words
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready) begin
            n_req++;
            if (cur_typed) push_word(0, 0, 1, cur_st);
            else plan_path(req_if.start_x, req_if.start_y, req_if.goal_x, req_if.goal_y,
                           req_if.obstacle_x, req_if.obstacle_y);
        end
    end

    // accepted response word: compare with the oldest expectation
    always @(posedge i_clk) begin
        t_cell_word w;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_words++;
            if (path_q.size() == 0) begin
                $error("unexpected word x=%0d y=%0d last=%0b status=%0d",
                       rsp_if.cell_x, rsp_if.cell_y, rsp_if.last, rsp_if.status);
                errors++;
            end else begin
                w = path_q.pop_front();
                if (w.st == STAT_BLOCKED) n_blocked++;
                if (w.st == STAT_RANGE) n_range++;
                if (rsp_if.cell_x !== w.x) begin
                    $error("cell_x expected %0d got %0d", w.x, rsp_if.cell_x);
                    errors++;
                end
                if (rsp_if.cell_y !== w.y) begin
                    $error("cell_y expected %0d got %0d", w.y, rsp_if.cell_y);
                    errors++;
                end
                if (rsp_if.last !== w.last) begin
                    $error("last expected %0b got %0b", w.last, rsp_if.last);
                    errors++;
                end
                if (rsp_if.status !== w.st) begin
                    $error("status expected %0d got %0d", w.st, rsp_if.status);
                    errors++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 120);
    endfunction

    // receiver: random ready runs, one long hold-off early in the random part
    initial begin
        int n;
        rsp_if.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (random_phase && !hold_done && path_q.size() > 0) begin
                hold_done = 1;
                rsp_if.ready <= 1'b0;
                for (int c = 0; c < HOLD_LONG; c++) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            n = $urandom_range(1, 40);
            repeat (n) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // hold one request until it is taken, idling first where a gap was drawn
    task automatic offer(int sx, int sy, int gx, int gy, int ox, int oy,
                         bit typed, t_status st);
        int n;
        n = pick_gap();
        if (n > 0 && req_if.valid) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.start_x    <= sx[7:0];
        req_if.start_y    <= sy[7:0];
        req_if.goal_x     <= gx[7:0];
        req_if.goal_y     <= gy[7:0];
        req_if.obstacle_x <= ox[7:0];
        req_if.obstacle_y <= oy[7:0];
        cur_typed <= typed;
        cur_st <= st;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    function automatic int on_axis();
        return $urandom_range(0, 2 * GH) - GH;
    endfunction

    function automatic int any_byte();
        int v;
        v = $urandom_range(0, 255);
        return v >= 128 ? v - 256 : v;
    endfunction

    t_row rows[$];

    initial begin
        int sx, sy, gx, gy, ox, oy, r;
        req_if.valid = 1'b0;
        req_if.start_x = '0; req_if.start_y = '0;
        req_if.goal_x = '0; req_if.goal_y = '0;
        req_if.obstacle_x = '0; req_if.obstacle_y = '0;

        // start equals goal, corners, diagonals across the whole grid
        rows.push_back('{0, 0, 0, 0, 99, 99, 0, STAT_PATH});
        rows.push_back('{-10, -10, 10, 10, -128, -128, 0, STAT_PATH});
        rows.push_back('{10, 10, -10, -10, 127, 127, 0, STAT_PATH});
        rows.push_back('{-10, 10, 10, -10, 0, 0, 0, STAT_PATH});
        rows.push_back('{10, -10, -10, 10, 5, -5, 0, STAT_PATH});
        rows.push_back('{-10, 0, 10, 0, 0, 0, 0, STAT_PATH});
        rows.push_back('{0, -10, 0, 10, 0, 1, 0, STAT_PATH});
        rows.push_back('{3, 4, 3, 4, 3, 4 + 1, 0, STAT_PATH});
        rows.push_back('{2, 2, 3, 3, 2, 3, 0, STAT_PATH});
        // start sitting on the obstacle is allowed
        rows.push_back('{-4, 6, 7, -2, -4, 6, 0, STAT_PATH});
        // obstacle directly in the way
        rows.push_back('{-5, 0, 5, 0, -4, 0, 0, STAT_PATH});
        rows.push_back('{0, 0, 0, 0, 127, -128, 0, STAT_PATH});
        // goal on obstacle, also with start off grid
        rows.push_back('{0, 0, 4, 4, 4, 4, 1, STAT_BLOCKED});
        rows.push_back('{-128, 127, -10, 10, -10, 10, 1, STAT_BLOCKED});
        rows.push_back('{10, -10, 10, -10, 10, -10, 1, STAT_BLOCKED});
        // start or goal off grid
        rows.push_back('{-128, 0, 0, 0, 99, 99, 1, STAT_RANGE});
        rows.push_back('{0, 127, 0, 0, 99, 99, 1, STAT_RANGE});
        rows.push_back('{0, 0, 11, 0, 11, 0, 1, STAT_RANGE});
        rows.push_back('{0, 0, 0, -11, 0, -11, 1, STAT_RANGE});
        rows.push_back('{-1, -1, -128, 127, 85, -86, 1, STAT_RANGE});
        rows.push_back('{-86, 85, 85, -86, -1, -1, 1, STAT_RANGE});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i])
            offer(rows[i].sx, rows[i].sy, rows[i].gx, rows[i].gy, rows[i].ox, rows[i].oy,
                  rows[i].typed, rows[i].st);

        random_phase = 1;
        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            sx = on_axis(); sy = on_axis();
            gx = on_axis(); gy = on_axis();
            if (r < 50) begin
                // obstacle at or next to the goal, or anywhere on the grid
                if ($urandom_range(0, 1)) begin
                    ox = gx + $urandom_range(0, 2) - 1;
                    oy = gy + $urandom_range(0, 2) - 1;
                end else begin
                    ox = on_axis(); oy = on_axis();
                end
            end else if (r < 65) begin
                ox = any_byte(); oy = any_byte();
            end else if (r < 75) begin
                ox = gx; oy = gy;
            end else if (r < 85) begin
                sx = any_byte(); sy = any_byte();
                gx = any_byte(); gy = any_byte();
                ox = any_byte(); oy = any_byte();
            end else begin
                // short hops
                gx = sx + $urandom_range(0, 4) - 2;
                gy = sy + $urandom_range(0, 4) - 2;
                ox = sx + $urandom_range(0, 2) - 1;
                oy = sy + $urandom_range(0, 2) - 1;
            end
            offer(sx, sy, gx, gy, ox, oy, 0, STAT_PATH);
        end
        req_if.valid <= 1'b0;

        // let the last accepted request reach the expectation queue
        @(posedge i_clk);
        while (path_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d requests, %0d words checked (%0d blocked, %0d off grid), %0d errors",
                 n_req, n_words, n_blocked, n_range, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
